/* sv/gctl_pkg.sv */
// Package for the gamma curve with linear toe: widths, latencies, register
// codes, the coefficient struct and the constant factors of the exp2 chain.
// No dependencies.
`default_nettype none

package gctl_pkg;

    // Sample and coefficient formats
    localparam int SAMPLE_BITS     = 16;
    localparam int COEFF_FRAC_BITS = 16;

    // Register widths
    localparam int THR_W      = 17;
    localparam int SLOPE_W    = 24;
    localparam int SCALE_W    = 18;
    localparam int OFFSET_W   = 17;
    localparam int EXPO_W     = 18;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // Power path widths
    localparam int FRAC_W  = 30;                       // log2 fraction bits
    localparam int MANT_W  = FRAC_W + 1;               // Q1.30 mantissa
    localparam int V_W     = SCALE_W + SAMPLE_BITS + 1; // signed base
    localparam int U_W     = V_W - 1;
    localparam int P_W     = $clog2(U_W);
    localparam int FB      = COEFF_FRAC_BITS + SAMPLE_BITS;
    localparam int IP_W    = P_W + 2;                  // signed integer part of log2
    localparam int PA_W    = FRAC_W + EXPO_W;
    localparam int PB_W    = IP_W + EXPO_W + 1;
    localparam int Y_W     = PB_W + FRAC_W + 1;
    localparam int N_W     = Y_W - FRAC_W - COEFF_FRAC_BITS;
    localparam int NS_W    = 6;                        // shift count kept after range check
    localparam int N_LIMIT = 40;
    localparam int R_W     = 32;                       // Q1.31 product
    localparam int SH_W    = 7;

    // Pipeline depth
    localparam int LOG_STEPS = FRAC_W;
    localparam int EXP_STEPS = FRAC_W;
    localparam int LOG_LAT   = LOG_STEPS + 2;
    localparam int MUL_LAT   = 2;
    localparam int EXP_LAT   = EXP_STEPS + 1;
    localparam int DLY       = LOG_LAT + MUL_LAT + EXP_LAT;
    localparam int LANE_LAT  = DLY + 2;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_SLOPE     = 3'd1,
        CFG_SCALE     = 3'd2,
        CFG_OFFSET    = 3'd3,
        CFG_EXPONENT  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [THR_W-1:0]           thr;
        logic [SLOPE_W-1:0]         slope;
        logic [SCALE_W-1:0]         scale;
        logic signed [OFFSET_W-1:0] offset;
        logic [EXPO_W-1:0]          expo;
    } t_curve_cfg;

    // Factor 2^-(2^-idx) in Q1.31 by repeated truncating square roots from 0.5
    function automatic logic [MANT_W-1:0] exp_factor(input int idx);
        logic [63:0] c;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        c = 64'd1 << 30;
        for (int i = 1; i <= idx; i++) begin
            x = c << 31;
            r = '0;
            b = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (b > x) begin
                    b = b >> 2;
                end
            end
            for (int j = 0; j < 32; j++) begin
                if (b != 0) begin
                    if (x >= r + b) begin
                        x = x - (r + b);
                        r = (r >> 1) + b;
                    end else begin
                        r = r >> 1;
                    end
                    b = b >> 2;
                end
            end
            c = r;
        end
        return c[MANT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/gamma_curve_linear_toe_core.sv */
// Gamma curve with linear toe: one 16-bit RGB pixel per clock in, one byte
// triple (blue, green, red) per clock out. Depth is set by the log2
// squaring chain (30 stages) and the exp2 factor chain (30 stages) in each
// channel lane. Throughput is one pixel per clock while the output is not
// stalled; a stall freezes the whole pipeline. The user writes coefficients
// through the register port only while the block is idle; the block does not enforce it.
`default_nettype none

module gamma_curve_linear_toe_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [15:0]                        i_red_sample,
    input  wire logic [15:0]                        i_green_sample,
    input  wire logic [15:0]                        i_blue_sample,
    input  wire logic                               i_last_pixel,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [7:0]                              o_blue_byte,
    output logic [7:0]                              o_green_byte,
    output logic [7:0]                              o_red_byte,
    output logic                                    o_last_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [gctl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gctl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int LAT = gctl_pkg::LANE_LAT;

    gctl_pkg::t_curve_cfg r_cfg;
    logic [LAT-1:0]       r_valid;
    logic                 r_last [0:LAT-1];
    logic                 en;

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr    <= gctl_pkg::THR_W'(6554);
            r_cfg.slope  <= gctl_pkg::SLOPE_W'(175920);
            r_cfg.scale  <= gctl_pkg::SCALE_W'(69541);
            r_cfg.offset <= -gctl_pkg::OFFSET_W'(4005);
            r_cfg.expo   <= gctl_pkg::EXPO_W'(27792);
        end else if (i_cfg_we) begin
            unique case (gctl_pkg::t_cfg_index'(i_cfg_index))
                gctl_pkg::CFG_THRESHOLD: r_cfg.thr    <= i_cfg_data[gctl_pkg::THR_W-1:0];
                gctl_pkg::CFG_SLOPE:     r_cfg.slope  <= i_cfg_data[gctl_pkg::SLOPE_W-1:0];
                gctl_pkg::CFG_SCALE:     r_cfg.scale  <= i_cfg_data[gctl_pkg::SCALE_W-1:0];
                gctl_pkg::CFG_OFFSET:    r_cfg.offset <= i_cfg_data[gctl_pkg::OFFSET_W-1:0];
                gctl_pkg::CFG_EXPONENT:  r_cfg.expo   <= i_cfg_data[gctl_pkg::EXPO_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances unless a finished result is held
    assign en      = !(r_valid[LAT-1] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last[0] <= i_last_pixel;
            for (int j = 1; j < LAT; j++) begin
                r_last[j] <= r_last[j-1];
            end
        end
    end

    // Channel lanes
    gctl_lane u_blue (
        .i_clk (i_clk), .i_en (en), .i_cfg (r_cfg),
        .i_sample (i_blue_sample), .o_byte (o_blue_byte)
    );
    gctl_lane u_green (
        .i_clk (i_clk), .i_en (en), .i_cfg (r_cfg),
        .i_sample (i_green_sample), .o_byte (o_green_byte)
    );
    gctl_lane u_red (
        .i_clk (i_clk), .i_en (en), .i_cfg (r_cfg),
        .i_sample (i_red_sample), .o_byte (o_red_byte)
    );

    // Occupancy count of requests in flight
    logic [$clog2(LAT+1)-1:0] occ;

    gctl_core u_occ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_in    (i_valid),
        .o_count (occ)
    );

    assign o_valid    = r_valid[LAT-1];
    assign o_last_out = r_last[LAT-1];

`ifndef SYNTHESIS
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a held result");
    a_occ_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ == $countones(r_valid))
        else $error("request count disagrees with pipeline valid bits");
    a_bad_index_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index > gctl_pkg::CFG_IDX_W'(gctl_pkg::CFG_EXPONENT))
        |=> $stable(r_cfg))
        else $error("write to unknown register changed coefficients");
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");
`endif

endmodule

`default_nettype wire

/* sv/gctl_log2.sv */
// Pipelined log2 of the positive curve base: leading one, normalise, then
// one squaring step per stage. Depends on gctl_pkg.
`default_nettype none

module gctl_log2 (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [gctl_pkg::V_W-1:0]    i_v,
    output logic signed [gctl_pkg::IP_W-1:0]        o_ip,
    output logic [gctl_pkg::FRAC_W-1:0]             o_frac,
    output logic                                    o_nonpos
);

    localparam int STEPS = gctl_pkg::LOG_STEPS;

    logic [gctl_pkg::U_W-1:0] r_u;
    logic [gctl_pkg::P_W-1:0] r_p0;
    logic                     r_np0;
    logic [gctl_pkg::P_W-1:0] n_p0;

    logic [gctl_pkg::MANT_W-1:0] r_m    [0:STEPS];
    logic [gctl_pkg::FRAC_W-1:0] r_frac [0:STEPS];
    logic [gctl_pkg::P_W-1:0]    r_p    [0:STEPS];
    logic                        r_np   [0:STEPS];

    logic [gctl_pkg::U_W+gctl_pkg::FRAC_W-1:0] norm;

    // Leading one position
    always_comb begin
        n_p0 = '0;
        for (int j = 0; j < gctl_pkg::U_W; j++) begin
            if (i_v[j]) begin
                n_p0 = gctl_pkg::P_W'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u   <= i_v[gctl_pkg::U_W-1:0];
            r_p0  <= n_p0;
            r_np0 <= i_v[gctl_pkg::V_W-1] | (i_v == '0);
        end
    end

    // Normalise to Q1.30
    assign norm = {r_u, {gctl_pkg::FRAC_W{1'b0}}} >> r_p0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]    <= norm[gctl_pkg::MANT_W-1:0];
            r_frac[0] <= '0;
            r_p[0]    <= r_p0;
            r_np[0]   <= r_np0;
        end
    end

    // One fraction bit per squaring
    for (genvar i = 1; i <= STEPS; i++) begin : g_sq
        logic [2*gctl_pkg::MANT_W-1:0] sq;
        logic [gctl_pkg::MANT_W:0]     t;
        assign sq = r_m[i-1] * r_m[i-1];
        assign t  = sq[2*gctl_pkg::MANT_W-1:gctl_pkg::FRAC_W];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[i]    <= t[gctl_pkg::MANT_W] ? t[gctl_pkg::MANT_W:1]
                                                 : t[gctl_pkg::MANT_W-1:0];
                r_frac[i] <= r_frac[i-1] | (t[gctl_pkg::MANT_W]
                             ? (gctl_pkg::FRAC_W'(1) << (gctl_pkg::FRAC_W - i)) : '0);
                r_p[i]    <= r_p[i-1];
                r_np[i]   <= r_np[i-1];
            end
        end
    end

    assign o_ip     = gctl_pkg::IP_W'({2'b00, r_p[STEPS]}) - gctl_pkg::IP_W'(gctl_pkg::FB);
    assign o_frac   = r_frac[STEPS];
    assign o_nonpos = r_np[STEPS];

endmodule

`default_nettype wire

/* sv/gctl_exp2.sv */
// Pipelined 2^-e: one constant factor per stage for each fraction bit, then
// the integer shift, zero forcing and saturation. Depends on gctl_pkg.
`default_nettype none

module gctl_exp2 (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [gctl_pkg::FRAC_W-1:0]       i_f,
    input  wire logic [gctl_pkg::NS_W-1:0]         i_n,
    input  wire logic                              i_zero,
    input  wire logic                              i_sat,
    output logic [gctl_pkg::SAMPLE_BITS-1:0]       o_pow
);

    localparam int STEPS = gctl_pkg::EXP_STEPS;
    localparam logic [gctl_pkg::SAMPLE_BITS-1:0] MAXV = '1;

    logic [gctl_pkg::R_W-1:0]    r_r    [1:STEPS];
    logic [gctl_pkg::FRAC_W-1:0] r_f    [1:STEPS];
    logic [gctl_pkg::NS_W-1:0]   r_n    [1:STEPS];
    logic                        r_zero [1:STEPS];
    logic                        r_sat  [1:STEPS];
    logic [gctl_pkg::SAMPLE_BITS-1:0] r_pow;

    // Product of factors, Q1.31
    for (genvar i = 1; i <= STEPS; i++) begin : g_fac
        localparam logic [gctl_pkg::MANT_W-1:0] C = gctl_pkg::exp_factor(i);
        logic [gctl_pkg::R_W-1:0]    src_r;
        logic [gctl_pkg::FRAC_W-1:0] src_f;
        logic [gctl_pkg::NS_W-1:0]   src_n;
        logic                        src_zero;
        logic                        src_sat;
        logic [gctl_pkg::R_W+gctl_pkg::MANT_W-1:0] prod;
        if (i == 1) begin : g_first
            assign src_r    = gctl_pkg::R_W'(1) << (gctl_pkg::R_W - 1);
            assign src_f    = i_f;
            assign src_n    = i_n;
            assign src_zero = i_zero;
            assign src_sat  = i_sat;
        end else begin : g_next
            assign src_r    = r_r[i-1];
            assign src_f    = r_f[i-1];
            assign src_n    = r_n[i-1];
            assign src_zero = r_zero[i-1];
            assign src_sat  = r_sat[i-1];
        end
        assign prod = src_r * C;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[i]    <= src_f[gctl_pkg::FRAC_W-i]
                             ? prod[gctl_pkg::R_W+gctl_pkg::MANT_W-1:gctl_pkg::R_W-1]
                             : src_r;
                r_f[i]    <= src_f;
                r_n[i]    <= src_n;
                r_zero[i] <= src_zero;
                r_sat[i]  <= src_sat;
            end
        end
    end

    // Integer part shift and saturation
    logic [gctl_pkg::SH_W-1:0] shamt;
    logic [gctl_pkg::R_W-1:0]  shr;
    assign shamt = gctl_pkg::SH_W'(gctl_pkg::R_W - 1 - gctl_pkg::SAMPLE_BITS)
                 + gctl_pkg::SH_W'(r_n[STEPS]);
    assign shr   = r_r[STEPS] >> shamt;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[STEPS]) begin
                r_pow <= '0;
            end else if (r_sat[STEPS] || shr > gctl_pkg::R_W'(MAXV)) begin
                r_pow <= MAXV;
            end else begin
                r_pow <= shr[gctl_pkg::SAMPLE_BITS-1:0];
            end
        end
    end

    assign o_pow = r_pow;

endmodule

`default_nettype wire

/* sv/gctl_lane.sv */
// One colour channel: linear toe, curve base, log2, exponent multiply,
// exp2 and final select. Depends on gctl_pkg, gctl_log2 and gctl_exp2.
`default_nettype none

module gctl_lane (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire gctl_pkg::t_curve_cfg                i_cfg,
    input  wire logic [15:0]                         i_sample,
    output logic [7:0]                               o_byte
);

    localparam int S = gctl_pkg::SAMPLE_BITS;
    localparam int F = gctl_pkg::COEFF_FRAC_BITS;
    localparam logic [S-1:0] MAXV = '1;

    // Front stage: toe, its select, and the curve base
    logic [S-1:0]                         k;
    logic [gctl_pkg::SLOPE_W+S-1:0]       lin_prod;
    logic [gctl_pkg::SLOPE_W+S-F-1:0]     lin_t;
    logic [gctl_pkg::SCALE_W+S-1:0]       sk;
    logic signed [gctl_pkg::V_W-1:0]      offs_ext;
    logic signed [gctl_pkg::V_W-1:0]      n_v;

    logic [S-1:0]                         r_a_lin;
    logic                                 r_a_isl;
    logic signed [gctl_pkg::V_W-1:0]      r_a_v;

    assign k        = i_sample[S-1:0];
    assign lin_prod = i_cfg.slope * k;
    assign lin_t    = lin_prod[gctl_pkg::SLOPE_W+S-1:F];
    assign sk       = i_cfg.scale * k;
    assign offs_ext = {{(gctl_pkg::V_W-gctl_pkg::OFFSET_W-S){i_cfg.offset[gctl_pkg::OFFSET_W-1]}},
                       i_cfg.offset, {S{1'b0}}};
    assign n_v      = $signed({1'b0, sk}) + offs_ext;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_isl <= gctl_pkg::THR_W'(k) < i_cfg.thr;
            r_a_lin <= (lin_t > (gctl_pkg::SLOPE_W+S-F)'(MAXV)) ? MAXV : lin_t[S-1:0];
            r_a_v   <= n_v;
        end
    end

    // log2 of base
    logic signed [gctl_pkg::IP_W-1:0] lg_ip;
    logic [gctl_pkg::FRAC_W-1:0]      lg_frac;
    logic                             lg_np;

    gctl_log2 u_log2 (
        .i_clk    (i_clk),
        .i_en     (i_en),
        .i_v      (r_a_v),
        .o_ip     (lg_ip),
        .o_frac   (lg_frac),
        .o_nonpos (lg_np)
    );

    // Exponent multiply, split into integer and fraction products
    logic [gctl_pkg::PA_W-1:0]        r_pa;
    logic signed [gctl_pkg::PB_W-1:0] r_pb;
    logic                             r_m_np;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa   <= lg_frac * i_cfg.expo;
            r_pb   <= lg_ip * $signed({1'b0, i_cfg.expo});
            r_m_np <= lg_np;
        end
    end

    // Sum, negate and split into shift and fraction
    logic signed [gctl_pkg::Y_W-1:0] y;
    logic [gctl_pkg::Y_W-1:0]        ny;
    logic [gctl_pkg::N_W-1:0]        nfull;

    logic [gctl_pkg::FRAC_W-1:0] r_e_f;
    logic [gctl_pkg::NS_W-1:0]   r_e_n;
    logic                        r_e_zero;
    logic                        r_e_sat;

    assign y     = ($signed(gctl_pkg::Y_W'(r_pb)) <<< gctl_pkg::FRAC_W)
                 + $signed(gctl_pkg::Y_W'({1'b0, r_pa}));
    assign ny    = '0 - y;
    assign nfull = ny[gctl_pkg::Y_W-1:gctl_pkg::FRAC_W+F];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_f    <= ny[gctl_pkg::FRAC_W+F-1:F];
            r_e_n    <= nfull[gctl_pkg::NS_W-1:0];
            r_e_sat  <= !r_m_np && !y[gctl_pkg::Y_W-1];
            r_e_zero <= r_m_np || (y[gctl_pkg::Y_W-1] &&
                        nfull >= gctl_pkg::N_W'(gctl_pkg::N_LIMIT));
        end
    end

    // 2^-e
    logic [S-1:0] pow;

    gctl_exp2 u_exp2 (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_f    (r_e_f),
        .i_n    (r_e_n),
        .i_zero (r_e_zero),
        .i_sat  (r_e_sat),
        .o_pow  (pow)
    );

    // Toe result rides alongside the power path
    logic [S-1:0] r_lin_d [0:gctl_pkg::DLY-1];
    logic         r_isl_d [0:gctl_pkg::DLY-1];
    logic [7:0]   r_byte;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lin_d[0] <= r_a_lin;
            r_isl_d[0] <= r_a_isl;
            for (int j = 1; j < gctl_pkg::DLY; j++) begin
                r_lin_d[j] <= r_lin_d[j-1];
                r_isl_d[j] <= r_isl_d[j-1];
            end
        end
    end

    // High byte of the chosen curve value
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byte <= r_isl_d[gctl_pkg::DLY-1] ? r_lin_d[gctl_pkg::DLY-1][S-1:S-8]
                                               : pow[S-1:S-8];
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

/* sv/gctl_core.sv */
// Request counter of the pipeline, used by the top level for occupancy checks.
// Depends on gctl_pkg.
`default_nettype none

module gctl_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_in,
    output logic [$clog2(gctl_pkg::LANE_LAT+1)-1:0]    o_count
);

    localparam int CW = $clog2(gctl_pkg::LANE_LAT + 1);

    logic [gctl_pkg::LANE_LAT-1:0] r_v;
    logic [CW-1:0]                 r_count;

    // Valid bits of the pipeline and their count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_count <= '0;
        end else if (i_en) begin
            r_v     <= {r_v[gctl_pkg::LANE_LAT-2:0], i_in};
            r_count <= r_count + CW'(i_in) - CW'(r_v[gctl_pkg::LANE_LAT-1]);
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire
